// File: design/ohm_pkg.sv
// Shared types and constants of the output health monitor.
package ohm_pkg;

  // Number of monitored channels and depth of the blanking table.
  localparam int CHANNELS    = 16;
  localparam int BLANK_DEPTH = 16;

  // Channel test thresholds in 1/16 units.
  localparam logic signed [16:0] DROP_LIMIT = 17'sd24;
  localparam logic [15:0]        CUR_LIMIT  = 16'd8;
  localparam logic [15:0]        VOLT_LIMIT = 16'd80;

  // Hysteresis in whole degrees.
  localparam logic signed [8:0] SHUT_HYST = 9'sd10;
  localparam logic signed [8:0] WARN_HYST = 9'sd5;

  // Lamp blink: on while tick modulo LAMP_PERIOD exceeds LAMP_ON.
  localparam logic [9:0]  LAMP_PERIOD  = 10'd1000;
  localparam logic [9:0]  LAMP_ON      = 10'd500;
  // tick / 1000 == (tick * DIV_MUL) >> DIV_SHIFT for every 32-bit tick.
  localparam logic [29:0] DIV_MUL      = 30'd274877907;
  localparam int          DIV_SHIFT    = 38;

  localparam logic [19:0] SUM_MAX = 20'hFFFFF;

  // Error flag bits.
  localparam int ERR_TRIP  = 0;
  localparam int ERR_FAULT = 1;
  localparam int ERR_WARN  = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SHUTDOWN_TEMP   = 2'd0;
  localparam logic [1:0] REG_WARNING_TEMP    = 2'd1;
  localparam logic [1:0] REG_BLANKING_TICKS  = 2'd2;
  localparam logic [1:0] REG_LOW_INPUT_LEVEL = 2'd3;

  localparam logic signed [7:0] SHUTDOWN_TEMP_RST   = 8'sd85;
  localparam logic signed [7:0] WARNING_TEMP_RST    = 8'sd70;
  localparam logic [15:0]       BLANKING_TICKS_RST  = 16'd500;
  localparam logic [15:0]       LOW_INPUT_LEVEL_RST = 16'd368;

  typedef struct packed {
    logic [3:0]          channel;
    logic [15:0]         switch_mask;
    logic                tripped;
    logic [15:0]         out_voltage;
    logic [15:0]         out_current;
    logic [15:0]         in_voltage;
    logic signed [15:0]  temperature;
    logic [31:0]         tick;
    logic                last_channel;
  } sample_t;

  typedef struct packed {
    logic [15:0] test_fault_mask;
    logic [2:0]  error_flags;
    logic [15:0] new_trip_mask;
    logic [2:0]  new_error_flags;
    logic [15:0] new_fault_mask;
    logic        any_alert;
    logic        over_temp;
    logic        temp_warn;
    logic [19:0] total_current;
    logic        fault_lamp;
  } report_t;

endpackage

// File: design/ohm_if.sv
// Valid/ready channel interfaces for samples and scan reports.
interface ohm_sample_if;
  logic             valid;
  logic             ready;
  ohm_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ohm_report_if;
  logic             valid;
  logic             ready;
  ohm_pkg::report_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/output_health_monitor.sv
// Output health monitor: per-channel test, scan accumulation and scan report.
//
//   channel   direction  transaction
//   sample    in         one channel sample of a scan
//   report    out        one scan report, issued for each last-channel sample
//   wr_*      in         configuration register write, no handshake
//
// One sample is taken every cycle while sample.ready is high. A last-channel
// sample passes the sample register, then a report stage that also holds the
// tick quotient, then the output register that finishes the lamp of its report.
// Reset clears the scan state, the blanking table included, and sets over_temp.
// When report is stalled, reports back up and only a last-channel sample
// waits; other samples keep flowing until one is held, which stalls the input.
module output_health_monitor (
  input  logic              clk,
  input  logic              rst,
  ohm_sample_if.sink        sample,
  ohm_report_if.source      report,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [15:0]       wr_data
);

  // Configuration registers.
  logic signed [7:0] shutdown_temp;
  logic signed [7:0] warning_temp;
  logic [15:0]       blanking_ticks;
  logic [15:0]       low_input_level;

  // Scan state.
  logic [31:0] blank_until [ohm_pkg::BLANK_DEPTH];
  logic [15:0] prev_switch_mask;
  logic [15:0] prev_trip_mask;
  logic [15:0] prev_fault_mask;
  logic [2:0]  prev_error_flags;
  logic [15:0] scan_fault_mask;
  logic [15:0] scan_trip_mask;
  logic [19:0] current_sum;
  logic        over_temp_flag;
  logic        warn_flag;

  // Pipeline registers.
  logic             s1_valid;
  ohm_pkg::sample_t s1;
  logic             mid_valid;
  ohm_pkg::report_t mid;
  logic             mid_low_input;
  logic [9:0]       mid_quot;
  logic [9:0]       mid_tick;
  logic             out_valid;
  ohm_pkg::report_t out_data;

  // Handshake chain.
  logic out_free, mid_adv, mid_free, s1_adv;

  assign out_free     = !out_valid || report.ready;
  assign mid_adv      = mid_valid && out_free;
  assign mid_free     = !mid_valid || out_free;
  assign s1_adv       = s1_valid && (!s1.last_channel || mid_free);
  assign sample.ready = !s1_valid || s1_adv;
  assign report.valid = out_valid;
  assign report.data  = out_data;

  // Stage 1 logic.
  logic        in_range, mask_changed, blanked, fails;
  logic        a_sw, b_drop, c_cur, d_volt;
  logic [31:0] blank_sel, blank_new;
  logic [16:0] drop;
  logic [15:0] ch_bit, fault_next, trip_next;
  logic [20:0] sum_wide;
  logic [19:0] sum_next;
  logic signed [16:0] temp_x, shut_hi, shut_lo, warn_hi, warn_lo;
  logic        over_next, warn_next;
  logic [2:0]  err;
  logic [15:0] new_trip, new_fault;
  logic [2:0]  new_err;
  logic [61:0] quot_prod;

  always_comb begin
    in_range     = int'(s1.channel) < ohm_pkg::CHANNELS;
    mask_changed = s1.switch_mask != prev_switch_mask;
    blank_new    = s1.tick + {16'd0, blanking_ticks};
    blank_sel    = mask_changed ? blank_new : blank_until[s1.channel];
    blanked      = s1.tick < blank_sel;

    a_sw   = s1.switch_mask[s1.channel];
    drop   = {1'b0, s1.in_voltage} - {1'b0, s1.out_voltage};
    b_drop = $signed(drop) < ohm_pkg::DROP_LIMIT;
    c_cur  = s1.out_current > ohm_pkg::CUR_LIMIT;
    d_volt = s1.out_voltage > ohm_pkg::VOLT_LIMIT;
    fails  = !(!(a_sw || b_drop || c_cur || d_volt) || (a_sw && b_drop && d_volt));

    ch_bit     = 16'd1 << s1.channel;
    fault_next = scan_fault_mask | ((in_range && !blanked && fails) ? ch_bit : 16'd0);
    trip_next  = scan_trip_mask | ((in_range && s1.tripped) ? ch_bit : 16'd0);

    sum_wide = {1'b0, current_sum} + {5'd0, s1.out_current};
    sum_next = sum_wide[20] ? ohm_pkg::SUM_MAX : sum_wide[19:0];

    // Thresholds are whole degrees; temperature is in 1/16 degree.
    temp_x  = 17'($signed(s1.temperature));
    shut_hi = 17'($signed({shutdown_temp, 4'd0}));
    shut_lo = 17'($signed({9'(shutdown_temp) - ohm_pkg::SHUT_HYST, 4'd0}));
    warn_hi = 17'($signed({warning_temp, 4'd0}));
    warn_lo = 17'($signed({9'(warning_temp) - ohm_pkg::WARN_HYST, 4'd0}));
    over_next = (temp_x > shut_hi) || ((temp_x > shut_lo) && over_temp_flag);
    warn_next = (temp_x > warn_hi) || ((temp_x > warn_lo) && warn_flag);

    err = 3'd0;
    err[ohm_pkg::ERR_TRIP]  = trip_next != 16'd0;
    err[ohm_pkg::ERR_FAULT] = fault_next != 16'd0;
    err[ohm_pkg::ERR_WARN]  = warn_next;
    new_trip  = trip_next & ~prev_trip_mask;
    new_fault = fault_next & ~prev_fault_mask;
    new_err   = err & ~prev_error_flags;

    quot_prod = 62'(s1.tick) * 62'(ohm_pkg::DIV_MUL);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_temp   <= ohm_pkg::SHUTDOWN_TEMP_RST;
      warning_temp    <= ohm_pkg::WARNING_TEMP_RST;
      blanking_ticks  <= ohm_pkg::BLANKING_TICKS_RST;
      low_input_level <= ohm_pkg::LOW_INPUT_LEVEL_RST;
    end else if (wr_en) begin
      case (wr_index)
        ohm_pkg::REG_SHUTDOWN_TEMP:   shutdown_temp   <= wr_data[7:0];
        ohm_pkg::REG_WARNING_TEMP:    warning_temp    <= wr_data[7:0];
        ohm_pkg::REG_BLANKING_TICKS:  blanking_ticks  <= wr_data;
        ohm_pkg::REG_LOW_INPUT_LEVEL: low_input_level <= wr_data;
        default: ;
      endcase
    end
  end

  // Sample register and scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      prev_switch_mask <= '0;
      prev_trip_mask   <= '0;
      prev_fault_mask  <= '0;
      prev_error_flags <= '0;
      scan_fault_mask  <= '0;
      scan_trip_mask   <= '0;
      current_sum      <= '0;
      over_temp_flag   <= 1'b1;
      warn_flag        <= 1'b0;
      for (int i = 0; i < ohm_pkg::BLANK_DEPTH; i++) begin
        blank_until[i] <= '0;
      end
    end else begin
      if (sample.ready) begin
        s1_valid <= sample.valid;
        s1       <= sample.data;
      end
      if (s1_adv) begin
        if (in_range && mask_changed) begin
          blank_until[s1.channel] <= blank_new;
        end
        if (s1.last_channel) begin
          prev_switch_mask <= s1.switch_mask;
          prev_trip_mask   <= trip_next;
          prev_fault_mask  <= fault_next;
          prev_error_flags <= err;
          scan_fault_mask  <= '0;
          scan_trip_mask   <= '0;
          current_sum      <= '0;
          over_temp_flag   <= over_next;
          warn_flag        <= warn_next;
        end else begin
          scan_fault_mask <= fault_next;
          scan_trip_mask  <= trip_next;
          current_sum     <= sum_next;
        end
      end
    end
  end

  // Report stage: everything but the lamp phase, plus the tick quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= (s1_adv && s1.last_channel) || (mid_valid && !mid_adv);
      if (s1_adv && s1.last_channel) begin
        mid.test_fault_mask       <= fault_next;
        mid.error_flags           <= err;
        mid.new_trip_mask         <= new_trip;
        mid.new_error_flags       <= new_err;
        mid.new_fault_mask        <= new_fault;
        mid.any_alert             <= (new_trip != 16'd0) || (new_err != 3'd0) ||
                                     (new_fault != 16'd0);
        mid.over_temp             <= over_next;
        mid.temp_warn             <= warn_next;
        mid.total_current         <= sum_next;
        mid.fault_lamp            <= 1'b0;
        mid_low_input             <= s1.in_voltage < low_input_level;
        mid_quot                  <= quot_prod[ohm_pkg::DIV_SHIFT +: 10];
        mid_tick                  <= s1.tick[9:0];
      end
    end
  end

  // Output register; the remainder only needs its low ten bits.
  logic [9:0]       rem;
  ohm_pkg::report_t out_next;

  always_comb begin
    rem = mid_tick - 10'(mid_quot * ohm_pkg::LAMP_PERIOD);
    out_next            = mid;
    out_next.fault_lamp = mid_low_input && (rem > ohm_pkg::LAMP_ON);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= mid_valid;
      end
      if (mid_adv) begin
        out_data <= out_next;
      end
    end
  end

endmodule
